// File: src/unordered_key_set_table_unit_macros.svh
// Assertion macros for the unordered key set table unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef UNORDERED_KEY_SET_TABLE_UNIT_MACROS_SVH
`define UNORDERED_KEY_SET_TABLE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i, off during reset.
`define UKS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off during reset.
`define UKS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UKS_ASSERT_IMP(label, ante, cons, msg)
`define UKS_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// File: src/uks_pkg.sv
// Shared types and constants for the unordered key set table unit.
// No dependencies; imported by every other file but the macros header.
package uks_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned KEY_IN_W = 32;
  localparam int unsigned ENTRY_W  = 32;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_FIND   = 3'd2,
    MODE_FIRST  = 3'd3,
    MODE_NEXT   = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK   = 2'd0,
    STAT_FAIL = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_WALK,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_BITS-1:0] wr_data;
  } ram_req_t;

  typedef struct packed {
    status_e              status;
    logic                 hit;
    logic [ENTRY_W-1:0]   entry;
    logic                 entry_valid;
    logic [CNT_W-1:0]     occupancy;
  } res_t;

endpackage

// File: src/uks_in_if.sv
// Input channel of the key set table: valid/ready plus mode and key.
// Depends on uks_pkg for field widths.
interface uks_in_if import uks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KEY_IN_W-1:0] key;

  modport source (output valid, output mode, output key, input ready);
  modport sink   (input valid, input mode, input key, output ready);
endinterface

// File: src/uks_out_if.sv
// Result channel of the key set table: valid/ready plus the result fields.
// Depends on uks_pkg for field widths.
interface uks_out_if import uks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                hit;
  logic [ENTRY_W-1:0]  entry;
  logic                entry_valid;
  logic [CNT_W-1:0]    occupancy;

  modport source (output valid, output status, output hit, output entry,
                  output entry_valid, output occupancy, input ready);
  modport sink   (input valid, input status, input hit, input entry,
                  input entry_valid, input occupancy, output ready);
endinterface

// File: src/uks_key_ram.sv
// Key store: one write port and one read port with registered read data.
// Depends on uks_pkg for depth, key width and the request struct.
module uks_key_ram import uks_pkg::*; (
  input  logic                clk_i,
  input  ram_req_t            req_i,
  output logic [KEY_BITS-1:0] rd_data_o
);

  logic [KEY_BITS-1:0] mem [CAPACITY];
  logic [KEY_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/uks_ctrl.sv
// Sequencer of the key set table: linear scan, append, swap-remove, walk.
// Depends on uks_pkg; drives the key store through a ram_req_t request.
module uks_ctrl import uks_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [KEY_IN_W-1:0] key_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o,
  output ram_req_t            ram_req_o,
  input  logic [KEY_BITS-1:0] ram_rd_data_i
);

  ctrl_state_e         state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    cursor_q, cursor_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic                cmp_v_q, cmp_v_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IDX_W-1:0]    pos_q, pos_d;
  res_t                res_q, res_d;
  logic [CNT_W-1:0]    walk_idx;
  logic                match;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      cmp_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      cmp_v_q  <= cmp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    pos_q     <= pos_d;
    res_q     <= res_d;
  end

  assign match = cmp_v_q && (ram_rd_data_i == key_q);

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    key_d       = key_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    idx_d       = idx_q;
    cmp_v_d     = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    pos_d       = pos_q;
    res_d       = res_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    ram_req_o   = '0;
    walk_idx    = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          mode_d = mode_e'(mode_i);
          key_d  = key_i[KEY_BITS-1:0];
          idx_d  = '0;
          res_d  = '{status: STAT_FAIL, hit: 1'b0, entry: '0, entry_valid: 1'b0,
                     occupancy: '0};
          case (mode_e'(mode_i))
            MODE_ADD, MODE_REMOVE, MODE_FIND: begin
              state_d = S_SCAN;
            end
            MODE_FIRST, MODE_NEXT: begin
              walk_idx = (mode_e'(mode_i) == MODE_FIRST) ? '0 : cursor_q;
              cursor_d = walk_idx;
              if (walk_idx < count_q) begin
                ram_req_o.rd_en   = 1'b1;
                ram_req_o.rd_addr = walk_idx[IDX_W-1:0];
                state_d           = S_WALK;
              end else begin
                state_d = S_DONE;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (match) begin
          pos_d     = cmp_idx_q;
          res_d.hit = 1'b1;
          case (mode_q)
            MODE_FIND: begin
              res_d.status      = STAT_OK;
              res_d.entry       = ENTRY_W'(ram_rd_data_i);
              res_d.entry_valid = 1'b1;
              state_d           = S_DONE;
            end
            MODE_REMOVE: begin
              // fetch the last entry to fill the hole
              res_d.status      = STAT_OK;
              ram_req_o.rd_en   = 1'b1;
              ram_req_o.rd_addr = IDX_W'(count_q - CNT_W'(1));
              state_d           = S_MOVE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (idx_q < count_q) begin
          ram_req_o.rd_en   = 1'b1;
          ram_req_o.rd_addr = idx_q[IDX_W-1:0];
          cmp_v_d           = 1'b1;
          cmp_idx_d         = idx_q[IDX_W-1:0];
          idx_d             = idx_q + CNT_W'(1);
        end else begin
          if (mode_q == MODE_ADD) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              res_d.status = STAT_FULL;
            end else begin
              ram_req_o.wr_en   = 1'b1;
              ram_req_o.wr_addr = count_q[IDX_W-1:0];
              ram_req_o.wr_data = key_q;
              count_d           = count_q + CNT_W'(1);
              res_d.status      = STAT_OK;
            end
          end
          state_d = S_DONE;
        end
      end

      S_MOVE: begin
        ram_req_o.wr_en   = 1'b1;
        ram_req_o.wr_addr = pos_q;
        ram_req_o.wr_data = ram_rd_data_i;
        count_d           = count_q - CNT_W'(1);
        cursor_d          = '0;
        state_d           = S_DONE;
      end

      S_WALK: begin
        res_d.status      = STAT_OK;
        res_d.entry       = ENTRY_W'(ram_rd_data_i);
        res_d.entry_valid = 1'b1;
        cursor_d          = cursor_q + CNT_W'(1);
        state_d           = S_DONE;
      end

      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o           = res_q;
    res_o.occupancy = count_q;
  end

endmodule

// File: src/unordered_key_set_table_unit.sv
// Unordered key set table: top level with the sequencer, key store and result register.
// A walk step passes S_WALK; unused modes and a walk past the end go straight to S_DONE; add
// and find scan the stored entries in S_SCAN, and remove also passes S_MOVE to fill the hole.
// One item at a time, held up by the one-entry-per-cycle scan: a new input beat is taken only
// in S_IDLE, after the previous result has been passed to the result register.
// Reset (rst_ni, async, active low) empties the table and rewinds the cursor at once.
`include "unordered_key_set_table_unit_macros.svh"
module unordered_key_set_table_unit import uks_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  uks_in_if.sink    in_i,
  uks_out_if.source out_o
);

  logic                in_ready;
  logic                res_valid;
  logic                res_ready;
  res_t                res;
  ram_req_t            ram_req;
  logic [KEY_BITS-1:0] ram_rd_data;
  logic                out_valid_q;
  res_t                out_q;

  uks_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_ready_o    (in_ready),
    .mode_i        (in_i.mode),
    .key_i         (in_i.key),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .ram_req_o     (ram_req),
    .ram_rd_data_i (ram_rd_data)
  );

  uks_key_ram u_key_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (ram_rd_data)
  );

  assign in_i.ready = in_ready;
  // load a new result whenever the register is empty or being drained
  assign res_ready  = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.hit         = out_q.hit;
  assign out_o.entry       = out_q.entry;
  assign out_o.entry_valid = out_q.entry_valid;
  assign out_o.occupancy   = out_q.occupancy;

  `UKS_ASSERT_IMP(a_occ_bound, out_valid_q, out_q.occupancy <= CNT_W'(CAPACITY), "occupancy overflow")
  `UKS_ASSERT_IMP(a_no_wr_idle, ram_req.wr_en, !in_ready, "key store written while idle")
  `UKS_ASSERT_NXT(a_busy_after_accept, in_i.valid && in_ready, !in_ready, "second beat while busy")
  `UKS_ASSERT_IMP(a_fail_no_entry, res_valid && (res.status != STAT_OK), !res.entry_valid, "entry on failure")

endmodule

// File: tb/sv/tb_unordered_key_set_table_unit.sv
// Self-checking testbench for the unordered key set table unit.
// Depends on uks_pkg, uks_in_if, uks_out_if and the unit's RTL;
// a built-in table model predicts each result beat.
module tb_unordered_key_set_table_unit import uks_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_STALL  = 300;
  localparam int unsigned KEY_POOL    = 20;
  localparam int unsigned RANDOM_OPS  = 430;

  typedef struct {
    logic [MODE_W-1:0]   op;
    logic [KEY_IN_W-1:0] key;
  } table_op_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  uks_in_if  in_if ();
  uks_out_if out_if ();

  unordered_key_set_table_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  table_op_t pending_ops[$];
  res_t      expected_results[$];

  // Mirror of the table contents, updated as each input beat is accepted.
  logic [KEY_BITS-1:0] held_keys [CAPACITY];
  logic [CNT_W-1:0]    held_count = '0;
  logic [CNT_W-1:0]    walk_pos   = '0;

  logic [KEY_IN_W-1:0] key_pool [KEY_POOL];
  int unsigned tx_idle_pct   = 30;
  int unsigned rx_idle_pct   = 47;
  bit          rx_stall_kick = 1'b0;
  int unsigned rx_stall_left;
  int unsigned cycle_count   = 0;
  bit          failed        = 1'b0;
  res_t        want;
  res_t        got;

  function automatic res_t apply_table_op(input logic [MODE_W-1:0] op,
                                          input logic [KEY_IN_W-1:0] key_in);
    res_t                r;
    logic [KEY_BITS-1:0] k;
    int unsigned         pos;
    r.status      = STAT_FAIL;
    r.hit         = 1'b0;
    r.entry       = '0;
    r.entry_valid = 1'b0;
    k   = KEY_BITS'(key_in);
    pos = held_count;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (held_keys[i] == k && pos == held_count) pos = i;
    end
    case (op)
      MODE_ADD: begin
        if (pos < held_count) begin
          r.hit = 1'b1;
        end else if (held_count >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          held_keys[held_count] = k;
          held_count++;
          r.status = STAT_OK;
        end
      end
      MODE_REMOVE: begin
        if (pos < held_count) begin
          // fill the hole with the last entry and rewind the walk
          held_keys[pos] = held_keys[held_count - 1];
          held_count--;
          walk_pos = '0;
          r.hit    = 1'b1;
          r.status = STAT_OK;
        end
      end
      MODE_FIND: begin
        if (pos < held_count) begin
          r.hit         = 1'b1;
          r.status      = STAT_OK;
          r.entry       = ENTRY_W'(held_keys[pos]);
          r.entry_valid = 1'b1;
        end
      end
      MODE_FIRST, MODE_NEXT: begin
        if (op == MODE_FIRST) walk_pos = '0;
        if (walk_pos < held_count) begin
          r.entry       = ENTRY_W'(held_keys[walk_pos]);
          r.entry_valid = 1'b1;
          r.status      = STAT_OK;
          walk_pos++;
        end
      end
      default: ;
    endcase
    r.occupancy = held_count;
    return r;
  endfunction

  // Driver: hold a beat until accepted, then offer the next pending op.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.mode  <= MODE_ADD;
      in_if.key   <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_results.push_back(apply_table_op(in_if.mode, in_if.key));
        void'(pending_ops.pop_front());
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_if.valid <= 1'b1;
          in_if.mode  <= pending_ops[0].op;
          in_if.key   <= pending_ops[0].key;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down once kicked.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_stall_left <= 0;
    end else if (rx_stall_kick) begin
      rx_stall_left <= LONG_STALL;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
    end
  end

  // Monitor: check each result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat status=%0d entry=%h", $time,
                   out_if.status, out_if.entry);
          failed = 1'b1;
        end else begin
          want             = expected_results.pop_front();
          got.status       = status_e'(out_if.status);
          got.hit          = out_if.hit;
          got.entry        = out_if.entry;
          got.entry_valid  = out_if.entry_valid;
          got.occupancy    = out_if.occupancy;
          if (got !== want) begin
            $display("%0t: mismatch expected status=%0d hit=%0b entry=%h ev=%0b occ=%0d",
                     $time, want.status, want.hit, want.entry, want.entry_valid,
                     want.occupancy);
            $display("%0t:          actual   status=%0d hit=%0b entry=%h ev=%0b occ=%0d",
                     $time, got.status, got.hit, got.entry, got.entry_valid,
                     got.occupancy);
            failed = 1'b1;
          end
        end
      end
      out_if.ready <= (rx_stall_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_op(input logic [MODE_W-1:0] op, input logic [KEY_IN_W-1:0] key);
    table_op_t t;
    t.op  = op;
    t.key = key;
    pending_ops.push_back(t);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || expected_results.size() != 0) @(negedge clk_i);
  endtask

  // Alternate fill-heavy and drain-heavy stretches so the table swings
  // between empty and full.
  task automatic queue_random_ops(input int unsigned n);
    int unsigned         r;
    int unsigned         add_pct;
    logic [MODE_W-1:0]   op;
    logic [KEY_IN_W-1:0] k;
    for (int unsigned i = 0; i < n; i++) begin
      add_pct = ((i / 60) % 2 == 0) ? 50 : 15;
      r = $urandom_range(99);
      if (r < add_pct)                          op = MODE_ADD;
      else if (r < add_pct + (65 - add_pct) / 2) op = MODE_REMOVE;
      else if (r < 65)                          op = MODE_FIND;
      else if (r < 75)                          op = MODE_FIRST;
      else if (r < 95)                          op = MODE_NEXT;
      else                                      op = MODE_W'($urandom_range(5, 7));
      k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(KEY_POOL - 1)] : $urandom;
      push_op(op, k);
    end
  endtask

  initial begin
    in_if.valid  = 1'b0;
    in_if.mode   = MODE_ADD;
    in_if.key    = '0;
    out_if.ready = 1'b0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int unsigned i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // empty table: walk past end, absent lookups, unused mode
    push_op(MODE_FIRST, 32'h0);
    push_op(MODE_FIND, 32'h0);
    push_op(MODE_REMOVE, 32'h5);
    push_op(3'd5, 32'h0);
    // extremes, duplicate, walk to the end and beyond
    push_op(MODE_ADD, 32'h0000_0000);
    push_op(MODE_ADD, 32'hFFFF_FFFF);
    push_op(MODE_ADD, 32'h0000_0000);
    push_op(MODE_FIND, 32'hFFFF_FFFF);
    push_op(MODE_FIRST, 32'h1234_5678);
    push_op(MODE_NEXT, 32'h0);
    push_op(MODE_NEXT, 32'h0);
    // fill up, then overflow with a new key and with a duplicate
    for (int unsigned i = 0; i < CAPACITY - 2; i++) push_op(MODE_ADD, 32'h8000_0001 + i);
    push_op(MODE_ADD, 32'h5A5A_A5A5);
    push_op(MODE_ADD, 32'hFFFF_FFFF);
    // remove from the front so the last entry moves, then walk again from the rewound cursor
    push_op(MODE_NEXT, 32'h0);
    push_op(MODE_REMOVE, 32'h0000_0000);
    push_op(MODE_NEXT, 32'h0);
    wait_drained();

    queue_random_ops(RANDOM_OPS);
    wait_drained();

    tx_idle_pct = 47;
    rx_idle_pct = 30;
    queue_random_ops(RANDOM_OPS);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_ops(RANDOM_OPS);
    // block the result side while inputs keep coming
    rx_stall_kick = 1'b1;
    @(negedge clk_i);
    rx_stall_kick = 1'b0;
    wait_drained();

    repeat (40) @(negedge clk_i);
    if (!failed) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
